[src/sed_pkg.sv]
// types, codes and byte tables shared by the string escape decoder
`default_nettype none

package sed_pkg;

  // decode mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_ESC  = 4'b0010,
    MODE_OCT  = 4'b0100,
    MODE_HEX  = 4'b1000
  } mode_e;

  typedef enum logic [2:0] {
    KIND_PLAIN    = 3'd0,
    KIND_SIMPLE   = 3'd1,
    KIND_OCT      = 3'd2,
    KIND_OCT_OVF  = 3'd3,
    KIND_HEX      = 3'd4,
    KIND_HEX_OVF  = 3'd5,
    KIND_UNKNOWN  = 3'd6,
    KIND_DANGLING = 3'd7
  } kind_e;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowerX = 8'h78;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] value;
    logic       ovf;
    logic       plain;
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    kind_e      kind;
    logic       start;
    logic       last;
  } res_t;

  localparam state_t StateReset = '{mode: MODE_IDLE, value: 8'd0, ovf: 1'b0, plain: 1'b0};

  // {is_digit, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    case (b) inside
      [8'h30:8'h39]: r = {1'b1, b[3:0]};
      [8'h41:8'h46], [8'h61:8'h66]: r = {1'b1, b[3:0] + 4'd9};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // {is_simple, mapped byte}
  function automatic logic [8:0] simple_escape(input logic [7:0] b);
    logic [8:0] r;
    r = 9'd0;
    case (b)
      8'h61: r = {1'b1, 8'h07};  // a
      8'h62: r = {1'b1, 8'h08};  // b
      8'h66: r = {1'b1, 8'h0C};  // f
      8'h6E: r = {1'b1, 8'h0A};  // n
      8'h72: r = {1'b1, 8'h0D};  // r
      8'h74: r = {1'b1, 8'h09};  // t
      8'h76: r = {1'b1, 8'h0B};  // v
      8'h22, 8'h27, 8'h5C: r = {1'b1, b};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[src/sed_decode.sv]
// per-byte decode: up to two results and the next decode state
`default_nettype none

module sed_decode (
  input  wire logic [7:0]    byte_i,
  input  wire logic          last_i,
  input  sed_pkg::state_t    state_i,
  output sed_pkg::state_t    state_o,
  output sed_pkg::res_t      res0_o,
  output sed_pkg::res_t      res1_o
);
  import sed_pkg::*;

  logic [4:0]  hex_d;
  logic [8:0]  simple_d;
  logic        is_oct;
  logic        numeric;
  logic        digit_ok;
  logic [11:0] acc;
  logic [7:0]  acc_value;
  logic        acc_ovf;
  kind_e       num_kind;
  res_t        num_res;
  res_t        tail_res;
  state_t      tail_st;
  mode_e       tail_mode;
  logic        tail_plain;

  assign hex_d    = hex_digit(byte_i);
  assign simple_d = simple_escape(byte_i);
  assign is_oct   = (byte_i[7:3] == 5'b00110);  // '0'..'7'
  assign numeric  = (state_i.mode == MODE_OCT) || (state_i.mode == MODE_HEX);
  assign digit_ok = (state_i.mode == MODE_OCT) ? is_oct : hex_d[4];

  // digits go into the zeroed low bits, so no adder is needed
  always_comb begin
    if (state_i.mode == MODE_OCT) begin
      acc = {1'b0, state_i.value, byte_i[2:0]};
    end else begin
      acc = {state_i.value, hex_d[3:0]};
    end
  end
  assign acc_value = acc[7:0];
  assign acc_ovf   = state_i.ovf | (|acc[11:8]);

  always_comb begin
    num_res       = '0;
    num_res.valid = 1'b1;
    num_res.start = 1'b1;
    if (digit_ok) begin
      num_res.data = acc_value;
      num_res.last = 1'b1;
      if (state_i.mode == MODE_OCT) begin
        num_kind = acc_ovf ? KIND_OCT_OVF : KIND_OCT;
      end else begin
        num_kind = acc_ovf ? KIND_HEX_OVF : KIND_HEX;
      end
    end else begin
      num_res.data = state_i.value;
      num_res.last = 1'b0;
      if (state_i.mode == MODE_OCT) begin
        num_kind = state_i.ovf ? KIND_OCT_OVF : KIND_OCT;
      end else begin
        num_kind = state_i.ovf ? KIND_HEX_OVF : KIND_HEX;
      end
    end
    num_res.kind = num_kind;
  end

  // the byte handled in escape or idle mode; a terminated numeric escape falls to idle
  assign tail_mode  = numeric ? MODE_IDLE : state_i.mode;
  assign tail_plain = numeric ? 1'b0 : state_i.plain;

  always_comb begin
    tail_res       = '0;
    tail_res.start = 1'b1;
    tail_res.last  = last_i;
    tail_st        = '{mode: MODE_IDLE, value: 8'd0, ovf: 1'b0, plain: 1'b0};
    case (tail_mode)
      MODE_ESC: begin
        if (simple_d[8]) begin
          tail_res.valid = 1'b1;
          tail_res.data  = simple_d[7:0];
          tail_res.kind  = KIND_SIMPLE;
        end else if (byte_i == ChLowerX) begin
          tail_st.mode   = MODE_HEX;
          tail_res.valid = last_i;
          tail_res.kind  = KIND_HEX;
        end else if (is_oct) begin
          tail_st.mode   = MODE_OCT;
          tail_st.value  = {5'd0, byte_i[2:0]};
          tail_res.valid = last_i;
          tail_res.data  = {5'd0, byte_i[2:0]};
          tail_res.kind  = KIND_OCT;
        end else begin
          tail_res.valid = 1'b1;
          tail_res.data  = byte_i;
          tail_res.kind  = KIND_UNKNOWN;
        end
      end
      default: begin
        if (byte_i == ChBslash) begin
          tail_st.mode   = MODE_ESC;
          tail_res.valid = last_i;
          tail_res.kind  = KIND_DANGLING;
        end else begin
          tail_res.valid = 1'b1;
          tail_res.data  = byte_i;
          tail_res.kind  = KIND_PLAIN;
          tail_res.start = ~tail_plain;
          tail_st.plain  = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    res0_o  = '0;
    res1_o  = '0;
    state_o = tail_st;
    if (numeric && digit_ok) begin
      state_o       = state_i;
      state_o.value = acc_value;
      state_o.ovf   = acc_ovf;
      if (last_i) begin
        res0_o = num_res;
      end
    end else if (numeric) begin
      res0_o = num_res;
      res1_o = tail_res;
      // a backslash terminator that is not the final byte opens an escape and gives nothing yet
      if (!tail_res.valid) begin
        res1_o = '0;
      end
    end else begin
      res0_o = tail_res;
    end
    if (last_i) begin
      state_o = StateReset;
    end
  end

endmodule

`default_nettype wire

[src/sed_out_stage.sv]
// result register plus one spare slot for the second result of an item
`default_nettype none

module sed_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          take_i,
  input  sed_pkg::res_t      res0_i,
  input  sed_pkg::res_t      res1_i,
  output logic               can_take_o,
  output sed_pkg::res_t      out_o,
  input  wire logic          ready_i
);
  import sed_pkg::*;

  logic out_v_q, out_v_d;
  logic spare_v_q, spare_v_d;
  res_t out_q, out_d;
  res_t spare_q, spare_d;
  logic out_free;

  assign out_free   = !out_v_q || ready_i;
  assign can_take_o = out_free && !spare_v_q;

  always_comb begin
    out_v_d   = out_v_q;
    spare_v_d = spare_v_q;
    out_d     = out_q;
    spare_d   = spare_q;
    if (out_free) begin
      if (spare_v_q) begin
        out_d     = spare_q;
        out_v_d   = 1'b1;
        spare_v_d = 1'b0;
      end else if (take_i && res0_i.valid) begin
        out_d   = res0_i;
        out_v_d = 1'b1;
        if (res1_i.valid) begin
          spare_d   = res1_i;
          spare_v_d = 1'b1;
        end
      end else begin
        out_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      spare_v_q <= 1'b0;
    end else begin
      out_v_q   <= out_v_d;
      spare_v_q <= spare_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    spare_q <= spare_d;
  end

  always_comb begin
    out_o       = out_q;
    out_o.valid = out_v_q;
  end

  a_spare_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_v_q |-> out_v_q) else $error("spare slot full while result register empty");

  a_no_take_with_spare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> !spare_v_q) else $error("item taken while a second result waits");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && res1_i.valid) |-> res0_i.valid) else $error("second result without first");

  a_second_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && res1_i.valid) |=> spare_v_q) else $error("second result dropped");

endmodule

`default_nettype wire

[src/string_escape_decoder.sv]
// top level of the string escape decoder: input register, decode state, result stage
//
//  channel  | group          | tdata            | tuser                        | tlast
//  ---------+----------------+------------------+------------------------------+-------------
//  in       | s_axis_*       | [7:0] data_byte  | -                            | last_byte
//  out      | m_axis_*       | [7:0] out_byte   | [2:0] seq_kind, [3] starts   | end_of_string
//
// one byte per cycle while the result stage can take it; a byte that terminates a numeric
// escape gives two results (one for a backslash that is not the final byte) and holds
// the input while the spare result slot drains
// a result passes through the input register, then the result register
// reset clears the decode state to idle and empties both stages
// output stalls back up through the spare slot and the input register to s_axis_tready
`default_nettype none

module string_escape_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic [3:0]       m_axis_tuser,   // [2:0] seq_kind, [3] starts_sequence
  output logic             m_axis_tlast
);
  import sed_pkg::*;

  logic       in_v_q, in_v_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  state_t     state_q, state_d;
  state_t     dec_state;
  res_t       res0, res1, out_res;
  logic       can_take;
  logic       take;

  assign take          = in_v_q && can_take;
  assign s_axis_tready = !in_v_q || can_take;
  assign in_v_d        = s_axis_tvalid || (in_v_q && !can_take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  sed_decode u_decode (
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .state_i (state_q),
    .state_o (dec_state),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  assign state_d = take ? dec_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else begin
      state_q <= state_d;
    end
  end

  sed_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .res0_i     (res0),
    .res1_i     (res1),
    .can_take_o (can_take),
    .out_o      (out_res),
    .ready_i    (m_axis_tready)
  );

  assign m_axis_tvalid = out_res.valid;
  assign m_axis_tdata  = out_res.data;
  assign m_axis_tuser  = {out_res.start, out_res.kind};
  assign m_axis_tlast  = out_res.last;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_last_q) |-> res0.valid) else $error("final byte gave no result");

  a_last_resets_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_last_q) |=> (state_q == StateReset)) else $error("state not idle after final byte");

  a_state_held_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(state_q)) else $error("decode state moved without an item");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the string escape decoder with a built-in decode predictor
`default_nettype none

module tb_top;
  import sed_pkg::*;

  localparam int unsigned NumItems    = 640;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned MaxReports  = 10;
  localparam logic [7:0]  SimpleSet [10] = '{"a", "b", "f", "n", "r", "t", "v", "\"", "'",
                                             ChBslash};

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'd0;  // [7:0] data_byte
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] out_byte
  logic [3:0] m_axis_tuser;          // [2:0] seq_kind, [3] starts_sequence
  logic       m_axis_tlast;

  string_escape_decoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  class escape_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      kind_e      kind;
      logic       start;
      logic       eos;
    } decoded_t;

    decoded_t    decoded_q[$];
    mode_e       mode;
    logic [7:0]  acc;
    logic        ovf;
    logic        plain_run;
    int unsigned errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      mode      = MODE_IDLE;
      acc       = 8'd0;
      ovf       = 1'b0;
      plain_run = 1'b0;
    endfunction

    function void add_decoded(logic [7:0] data, kind_e kind, logic start, logic eos);
      decoded_t r;
      r.data  = data;
      r.kind  = kind;
      r.start = start;
      r.eos   = eos;
      decoded_q.push_back(r);
    endfunction

    // predicts the decoded items caused by one accepted input item
    function void decode_input(logic [7:0] b, logic fin);
      kind_e       base;
      logic        is_dig;
      logic [7:0]  dig;
      logic [11:0] sum;
      logic        is_oct;
      is_oct = (b >= "0" && b <= "7");
      if (mode == MODE_OCT || mode == MODE_HEX) begin
        base   = (mode == MODE_OCT) ? KIND_OCT : KIND_HEX;
        is_dig = 1'b0;
        dig    = 8'd0;
        if (mode == MODE_OCT) begin
          if (is_oct) begin
            is_dig = 1'b1;
            dig    = b - "0";
          end
        end else if (b >= "0" && b <= "9") begin
          is_dig = 1'b1;
          dig    = b - "0";
        end else if (b >= "a" && b <= "f") begin
          is_dig = 1'b1;
          dig    = b - "a" + 8'd10;
        end else if (b >= "A" && b <= "F") begin
          is_dig = 1'b1;
          dig    = b - "A" + 8'd10;
        end
        if (is_dig) begin
          sum = ({4'd0, acc} << ((mode == MODE_OCT) ? 3 : 4)) + {4'd0, dig};
          if (sum > 12'd255) ovf = 1'b1;
          acc = sum[7:0];
          if (fin) begin
            add_decoded(acc, kind_e'(base + {2'd0, ovf}), 1'b1, 1'b1);
            clear_state();
          end
          return;
        end
        // the terminating byte is decoded afresh from idle
        add_decoded(acc, kind_e'(base + {2'd0, ovf}), 1'b1, 1'b0);
        clear_state();
      end

      if (mode == MODE_ESC) begin
        case (b)
          "a":                 add_decoded(8'h07, KIND_SIMPLE, 1'b1, fin);
          "b":                 add_decoded(8'h08, KIND_SIMPLE, 1'b1, fin);
          "f":                 add_decoded(8'h0C, KIND_SIMPLE, 1'b1, fin);
          "n":                 add_decoded(8'h0A, KIND_SIMPLE, 1'b1, fin);
          "r":                 add_decoded(8'h0D, KIND_SIMPLE, 1'b1, fin);
          "t":                 add_decoded(8'h09, KIND_SIMPLE, 1'b1, fin);
          "v":                 add_decoded(8'h0B, KIND_SIMPLE, 1'b1, fin);
          "\"", "'", ChBslash: add_decoded(b, KIND_SIMPLE, 1'b1, fin);
          ChLowerX: begin
            mode = MODE_HEX;
            acc  = 8'd0;
            ovf  = 1'b0;
            if (fin) add_decoded(8'd0, KIND_HEX, 1'b1, 1'b1);
          end
          default: begin
            if (is_oct) begin
              mode = MODE_OCT;
              acc  = b - "0";
              ovf  = 1'b0;
              if (fin) add_decoded(acc, KIND_OCT, 1'b1, 1'b1);
            end else begin
              add_decoded(b, KIND_UNKNOWN, 1'b1, fin);
            end
          end
        endcase
        if (mode == MODE_ESC) mode = MODE_IDLE;
        plain_run = 1'b0;
      end else if (b == ChBslash) begin
        plain_run = 1'b0;
        if (fin) add_decoded(8'd0, KIND_DANGLING, 1'b1, 1'b1);
        else mode = MODE_ESC;
      end else begin
        add_decoded(b, KIND_PLAIN, !plain_run, fin);
        plain_run = 1'b1;
      end

      if (fin) clear_state();
    endfunction

    function void check_output(logic [7:0] data, logic [3:0] user, logic eos);
      decoded_t w;
      if (decoded_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("unexpected item: byte %02h kind %0d start %b eos %b",
                   data, user[2:0], user[3], eos);
        return;
      end
      w = decoded_q.pop_front();
      if (data !== w.data || user[2:0] !== w.kind || user[3] !== w.start || eos !== w.eos) begin
        errors++;
        if (errors <= MaxReports)
          $display("mismatch: want byte %02h kind %0d start %b eos %b, got %02h %0d %b %b",
                   w.data, w.kind, w.start, w.eos, data, user[2:0], user[3], eos);
      end
    endfunction

    function int unsigned pending();
      return decoded_q.size();
    endfunction
  endclass

  escape_scoreboard sb = new();

  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          tx_steady  = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned rx_mode    = 0;
  int unsigned rx_cnt     = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // both handshakes are sampled here, inputs first so the predictor is never behind
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.decode_input(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata, m_axis_tuser,
                                                          m_axis_tlast);
    end
  end

  // receiver: own stall pattern, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      rx_cnt++;
      if (rx_cnt % 150 == 0) rx_mode = $urandom_range(0, 2);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 2) != 0);
          default: m_axis_tready <= ((rx_cnt % 7) < 4);
        endcase
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!tx_steady) begin
        s_axis_tvalid <= 1'b0;
        gap = $urandom_range(1, 5);
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  task automatic wait_empty();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(0, 21);
    if (v < 10) return "0" + v[7:0];
    if (v < 16) return "a" + v[7:0] - 8'd10;
    return "A" + v[7:0] - 8'd16;
  endfunction

  // one string of escapes, well-formed or unknown, and plain runs, salted with raw noise
  task automatic send_random_string();
    logic [7:0]  q[$];
    logic [7:0]  b;
    int unsigned nseq;
    int unsigned r;
    int unsigned n;
    nseq      = $urandom_range(1, 8);
    tx_steady = ($urandom_range(0, 3) == 0);
    for (int s = 0; s < nseq; s++) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          do b = 8'($urandom_range(0, 255)); while (b == ChBslash);
          q.push_back(b);
        end
      end else if (r < 42) begin
        q.push_back(ChBslash);
        q.push_back(SimpleSet[$urandom_range(0, 9)]);
      end else if (r < 60) begin
        q.push_back(ChBslash);
        n = $urandom_range(1, 5);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) q.push_back("0");
        repeat (n) q.push_back("0" + 8'($urandom_range(0, 7)));
      end else if (r < 78) begin
        q.push_back(ChBslash);
        q.push_back(ChLowerX);
        n = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) q.push_back("0");
        repeat (n) q.push_back(hex_char());
      end else if (r < 88) begin
        q.push_back(ChBslash);
        do b = 8'($urandom_range(0, 255));
        while (b == ChLowerX || (b >= "0" && b <= "7") || b inside {SimpleSet});
        q.push_back(b);
      end else begin
        q.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) == 0) q.push_back(ChBslash);
    foreach (q[i]) send_item(q[i], i == q.size() - 1);
  endtask

  initial begin
    bit hold_started;
    bit mid_paused;
    hold_started = 1'b0;
    mid_paused   = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // plain extremes, then the escape corner cases
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_text("\\777\\");     // octal overflow ended by a final backslash
    send_text("\\x");         // hex with no digits at the end
    send_text("\\xg");        // hex with no digits, then a terminator
    send_text("\\0012A");     // leading zeros
    send_text("\\x1FF");      // hex overflow on the final byte
    send_text("\\8");         // unknown escape
    send_text("\\");          // dangling backslash
    wait_empty();

    while (items_sent < NumItems) begin
      if (!hold_started && items_sent > 250) begin
        hold_req     = 1'b1;
        hold_started = 1'b1;
      end
      if (!mid_paused && items_sent > 450) begin
        wait_empty();
        mid_paused = 1'b1;
      end
      send_random_string();
    end

    wait_empty();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
